// ----- rtl/ibb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image block binning package
// Shared widths, register indexes, reset values and the pipeline stage record
// of the block-average downscaler.
// ----------------------------------------------------------------------------
package ibb_pkg;

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CHCNT_W    = 3;
  localparam int SAMPLE_W   = 8;
  localparam int COORD_W    = 10;
  localparam int CHAN_W     = 2;
  localparam int MAX_HEIGHT = 4096;

  localparam int BIN_DEFAULT          = 4;
  localparam int MAX_WIDTH_DEFAULT    = 4096;
  localparam int MAX_CHANNELS_DEFAULT = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [CFG_W-1:0]   RST_IMAGE_WIDTH   = 13'd640;
  localparam logic [CFG_W-1:0]   RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [CHCNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;

  typedef struct packed {
    logic                first;
    logic                write;
    logic                emit;
    logic                last;
    logic [SAMPLE_W-1:0] sample;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [CHAN_W-1:0]   chan;
  } stage_t;

endpackage

// ----- rtl/image_block_binning_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image block binning core
// Averages each channel of an interleaved raster over non-overlapping BIN by
// BIN blocks, keeping partial sums per output column and channel in a
// synchronous accumulator memory with read-modify-write and forwarding.
// ----------------------------------------------------------------------------
// Path: the request that closes a block passes through the read-modify-write
// stage and then the result register, which presents its average.
// Throughput: one sample per cycle, set by the single read and write port of
// the accumulator memory; a stalled result holds the pipeline.
// Reset: configuration returns to 640 x 480 with three channels and the frame
// position to its start; the accumulator memory is not cleared.
module image_block_binning_core #(
  parameter int BIN          = ibb_pkg::BIN_DEFAULT,
  parameter int MAX_WIDTH    = ibb_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_CHANNELS = ibb_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ibb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ibb_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ibb_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ibb_pkg::SAMPLE_W-1:0]  average_o,
  output logic [ibb_pkg::COORD_W-1:0]   out_column_o,
  output logic [ibb_pkg::COORD_W-1:0]   out_row_o,
  output logic [ibb_pkg::CHAN_W-1:0]    out_channel_o,
  output logic                          frame_last_o
);
  import ibb_pkg::*;

  localparam int SUM_W   = $clog2(BIN * BIN * 255 + 1);
  localparam int DEPTH   = (MAX_WIDTH / BIN) * MAX_CHANNELS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int OX_W    = (MAX_WIDTH / BIN > 1) ? $clog2(MAX_WIDTH / BIN) : 1;
  localparam int DX_W    = $clog2(BIN);
  localparam int XE_W    = CFG_W + 1;
  localparam int DIVISOR = BIN * BIN;
  localparam int RECIP_K = SUM_W + $clog2(DIVISOR);
  localparam int RECIP_M = ((1 << RECIP_K) + DIVISOR - 1) / DIVISOR;
  localparam int PROD_W  = SUM_W + RECIP_K + 1;

  // Configuration.
  logic [CFG_W-1:0]   width_q, width_d;
  logic [CFG_W-1:0]   height_q, height_d;
  logic [CHCNT_W-1:0] chan_cnt_q, chan_cnt_d;
  logic               restart;

  // Frame position of the next sample.
  logic [CFG_W-1:0]  x_q, x_d, ox_q, ox_d;
  logic [CFG_W-1:0]  y_q, y_d, oy_q, oy_d;
  logic [DX_W-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic [CHAN_W-1:0] chan_q, chan_d;

  logic              in_accept;
  logic              col_ok, row_ok, col_last, row_last, chan_last;
  logic              chan_wrap, col_wrap, row_wrap;
  stage_t            stage_d;
  logic [ADDR_W-1:0] addr_d;

  // Read-modify-write stage.
  logic              s1_valid_q;
  stage_t            s1_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic              s1_adv;

  logic [SUM_W-1:0]  sums_mem [DEPTH];
  logic [SUM_W-1:0]  rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [SUM_W-1:0]  wr_data;
  logic              fwd_q;
  logic [SUM_W-1:0]  fwd_data_q;
  logic [SUM_W-1:0]  base_sum;
  logic [PROD_W-1:0] prod;

  // Result register.
  logic                out_valid_q;
  logic                out_load;
  logic [SAMPLE_W-1:0] average_q;
  logic [COORD_W-1:0]  column_q, row_q;
  logic [CHAN_W-1:0]   channel_q;
  logic                last_q;

  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    chan_cnt_d = chan_cnt_q;
    restart    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          restart = 1'b1;
          if (cfg_data_i == '0) begin
            width_d = CFG_W'(1);
          end else if (XE_W'(cfg_data_i) > XE_W'(MAX_WIDTH)) begin
            width_d = CFG_W'(MAX_WIDTH);
          end else begin
            width_d = cfg_data_i;
          end
        end
        REG_IMAGE_HEIGHT: begin
          restart = 1'b1;
          if (cfg_data_i == '0) begin
            height_d = CFG_W'(1);
          end else if (XE_W'(cfg_data_i) > XE_W'(MAX_HEIGHT)) begin
            height_d = CFG_W'(MAX_HEIGHT);
          end else begin
            height_d = cfg_data_i;
          end
        end
        REG_CHANNEL_COUNT: begin
          restart = 1'b1;
          if (cfg_data_i[CHCNT_W-1:0] == '0) begin
            chan_cnt_d = CHCNT_W'(1);
          end else if (cfg_data_i[CHCNT_W-1:0] > CHCNT_W'(MAX_CHANNELS)) begin
            chan_cnt_d = CHCNT_W'(MAX_CHANNELS);
          end else begin
            chan_cnt_d = cfg_data_i[CHCNT_W-1:0];
          end
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!s1_q.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // A block lies inside the image when its far edges pass neither the width nor the height.
  always_comb begin
    col_ok    = (XE_W'(x_q) - XE_W'(dx_q) + XE_W'(BIN)) <= XE_W'(width_q);
    row_ok    = (XE_W'(y_q) - XE_W'(dy_q) + XE_W'(BIN)) <= XE_W'(height_q);
    col_last  = (XE_W'(x_q) - XE_W'(dx_q) + XE_W'(2 * BIN)) > XE_W'(width_q);
    row_last  = (XE_W'(y_q) - XE_W'(dy_q) + XE_W'(2 * BIN)) > XE_W'(height_q);
    chan_last = CHCNT_W'(chan_q) == chan_cnt_q - CHCNT_W'(1);

    stage_d.first  = (dx_q == '0) && (dy_q == '0);
    stage_d.write  = col_ok && row_ok;
    stage_d.emit   = col_ok && row_ok && (dx_q == DX_W'(BIN - 1))
                     && (dy_q == DX_W'(BIN - 1));
    stage_d.last   = col_last && row_last && chan_last;
    stage_d.sample = sample_i;
    stage_d.column = ox_q[COORD_W-1:0];
    stage_d.row    = oy_q[COORD_W-1:0];
    stage_d.chan   = chan_q;

    addr_d = ADDR_W'(ADDR_W'(ox_q[OX_W-1:0]) * ADDR_W'(MAX_CHANNELS))
             + ADDR_W'(chan_q);
  end

  always_comb begin
    chan_wrap = (CHCNT_W'(chan_q) + CHCNT_W'(1)) >= chan_cnt_q;
    col_wrap  = (XE_W'(x_q) + XE_W'(1)) >= XE_W'(width_q);
    row_wrap  = (XE_W'(y_q) + XE_W'(1)) >= XE_W'(height_q);
    x_d    = x_q;
    ox_d   = ox_q;
    dx_d   = dx_q;
    y_d    = y_q;
    oy_d   = oy_q;
    dy_d   = dy_q;
    chan_d = chan_q;
    if (restart) begin
      x_d    = '0;
      ox_d   = '0;
      dx_d   = '0;
      y_d    = '0;
      oy_d   = '0;
      dy_d   = '0;
      chan_d = '0;
    end else if (in_accept) begin
      if (!chan_wrap) begin
        chan_d = chan_q + CHAN_W'(1);
      end else begin
        chan_d = '0;
        if (!col_wrap) begin
          x_d = x_q + CFG_W'(1);
          if (dx_q == DX_W'(BIN - 1)) begin
            dx_d = '0;
            ox_d = ox_q + CFG_W'(1);
          end else begin
            dx_d = dx_q + DX_W'(1);
          end
        end else begin
          x_d  = '0;
          dx_d = '0;
          ox_d = '0;
          if (!row_wrap) begin
            y_d = y_q + CFG_W'(1);
            if (dy_q == DX_W'(BIN - 1)) begin
              dy_d = '0;
              oy_d = oy_q + CFG_W'(1);
            end else begin
              dy_d = dy_q + DX_W'(1);
            end
          end else begin
            y_d  = '0;
            dy_d = '0;
            oy_d = '0;
          end
        end
      end
    end
  end

  // A stalled entry re-reads its own address so the data stays current.
  assign rd_addr = in_accept ? addr_d : s1_addr_q;

  always_comb begin
    base_sum = fwd_q ? fwd_data_q : rd_data_q;
    if (s1_q.first) begin
      wr_data = SUM_W'(s1_q.sample);
    end else begin
      wr_data = base_sum + SUM_W'(s1_q.sample);
    end
    wr_en    = s1_adv && s1_q.write;
    prod     = PROD_W'(wr_data) * PROD_W'(RECIP_M);
    out_load = s1_adv && s1_q.emit;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sums_mem[s1_addr_q] <= wr_data;
    end
    rd_data_q <= sums_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= RST_IMAGE_WIDTH;
      height_q    <= RST_IMAGE_HEIGHT;
      chan_cnt_q  <= RST_CHANNEL_COUNT;
      x_q         <= '0;
      ox_q        <= '0;
      dx_q        <= '0;
      y_q         <= '0;
      oy_q        <= '0;
      dy_q        <= '0;
      chan_q      <= '0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      chan_cnt_q <= chan_cnt_d;
      x_q        <= x_d;
      ox_q       <= ox_d;
      dx_q       <= dx_d;
      y_q        <= y_d;
      oy_q       <= oy_d;
      dy_q       <= dy_d;
      chan_q     <= chan_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      fwd_q <= wr_en && (s1_addr_q == rd_addr);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
    if (in_accept) begin
      s1_q      <= stage_d;
      s1_addr_q <= addr_d;
    end
    if (out_load) begin
      average_q <= prod[RECIP_K +: SAMPLE_W];
      column_q  <= s1_q.column;
      row_q     <= s1_q.row;
      channel_q <= s1_q.chan;
      last_q    <= s1_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign average_o     = average_q;
  assign out_column_o  = column_q;
  assign out_row_o     = row_q;
  assign out_channel_o = channel_q;
  assign frame_last_o  = last_q;

endmodule
